// ----- design/eul_pkg.sv -----
`timescale 1ns / 1ps
// Package for the Euler XYZ rotation block: register indexes, data types,
// sine/cosine generator constants and elaboration-time table functions.
// No dependencies.
package eul_pkg;

    // default configuration of the block
    localparam int ANGLE_BITS_DEF     = 16;
    localparam int TRIG_FRAC_BITS_DEF = 16;

    // configuration register indexes
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ANGLE_X = 2'd0;
    localparam t_reg_idx REG_ANGLE_Y = 2'd1;
    localparam t_reg_idx REG_ANGLE_Z = 2'd2;
    localparam int       NUM_AXES    = 3;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 16;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    // one point as it travels through an axis stage: pair being rotated,
    // the coordinate kept, and the sticky clamp flag
    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] k;
        logic                      sat;
    } t_rot_data;

    // sine/cosine generator sequencer
    typedef enum logic [1:0] {
        TRIG_IDLE,
        TRIG_RUN,
        TRIG_DONE
    } t_trig_state;

    // CORDIC datapath: Q2.62 for x/y, angle in Q62 fractions of a full turn
    localparam int CORDIC_W     = 64;
    localparam int CORDIC_FRAC  = 62;
    localparam int CORDIC_ITERS = 56;
    localparam real PI_R        = 3.14159265358979323846;
    localparam real TURN_PER_RAD = 1.0 / (2.0 * PI_R);

    typedef logic signed [CORDIC_W-1:0] t_atan_tab [CORDIC_ITERS];

    // atan(2^-i) in Q62 turns, worked out at elaboration
    function automatic t_atan_tab atan_table();
        t_atan_tab tab;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            tab[i] = longint'($atan(2.0 ** (-i)) * TURN_PER_RAD * (2.0 ** CORDIC_FRAC));
        end
        return tab;
    endfunction

    // squared CORDIC growth over all micro-rotations
    function automatic real cordic_growth();
        real g;
        g = 1.0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            g = g * (1.0 + (2.0 ** (-2 * i)));
        end
        return g;
    endfunction

    localparam real CORDIC_INV_GAIN = 1.0 / $sqrt(cordic_growth());

    // inverse CORDIC gain in Q2.62
    function automatic logic signed [CORDIC_W-1:0] cordic_gain();
        return longint'(CORDIC_INV_GAIN * (2.0 ** CORDIC_FRAC));
    endfunction

endpackage

// ----- design/euler_xyz_vector_rotation.sv -----
`timescale 1ns / 1ps
// Euler XYZ rotation of a Q16.16 point: about X, then Y, then Z.
// Two register stages per axis; one point per cycle while no angle write is
// being processed and the output is not stalled. An angle write runs the
// shared CORDIC, during which s_axis_tready and o_cfg_ready are low. Synchronous
// active-low reset empties the pipeline and sets all angles to zero (sin 0, cos 1).
module euler_xyz_vector_rotation #(
    parameter int ANGLE_BITS     = eul_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = eul_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  eul_pkg::t_reg_idx             i_cfg_index,
    input  logic [eul_pkg::CFG_W-1:0]     i_cfg_data,
    // point input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata,  // coord_x, coord_y, coord_z
    // rotated point output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [95:0]                   m_axis_tdata,  // rotated_x, rotated_y, rotated_z
    output logic [0:0]                    m_axis_tuser   // saturated
);
    import eul_pkg::*;

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;

    logic                     busy;
    logic signed [TRIG_W-1:0] sin_v [NUM_AXES];
    logic signed [TRIG_W-1:0] cos_v [NUM_AXES];

    logic      x_valid, x_ready, xo_valid, y_ready, yo_valid, z_ready;
    t_rot_data x_in, x_out, y_in, y_out, z_in, z_out;

    // sine/cosine generator
    eul_trig_gen #(
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_sin       (sin_v),
        .o_cos       (cos_v)
    );

    // input transaction held off while sin/cos are being rebuilt
    assign x_valid       = s_axis_tvalid && !busy;
    assign s_axis_tready = x_ready && !busy;

    // about X: (y, z) rotate, x kept
    assign x_in.a   = s_axis_tdata[63:32];
    assign x_in.b   = s_axis_tdata[95:64];
    assign x_in.k   = s_axis_tdata[31:0];
    assign x_in.sat = 1'b0;

    eul_axis_rot #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x_valid),
        .o_ready (x_ready),
        .i_data  (x_in),
        .i_sin   (sin_v[REG_ANGLE_X]),
        .i_cos   (cos_v[REG_ANGLE_X]),
        .o_valid (xo_valid),
        .i_ready (y_ready),
        .o_data  (x_out)
    );

    // about Y: (z, x) rotate, y kept
    assign y_in.a   = x_out.b;
    assign y_in.b   = x_out.k;
    assign y_in.k   = x_out.a;
    assign y_in.sat = x_out.sat;

    eul_axis_rot #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xo_valid),
        .o_ready (y_ready),
        .i_data  (y_in),
        .i_sin   (sin_v[REG_ANGLE_Y]),
        .i_cos   (cos_v[REG_ANGLE_Y]),
        .o_valid (yo_valid),
        .i_ready (z_ready),
        .o_data  (y_out)
    );

    // about Z: (x, y) rotate, z kept
    assign z_in.a   = y_out.b;
    assign z_in.b   = y_out.k;
    assign z_in.k   = y_out.a;
    assign z_in.sat = y_out.sat;

    eul_axis_rot #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yo_valid),
        .o_ready (z_ready),
        .i_data  (z_in),
        .i_sin   (sin_v[REG_ANGLE_Z]),
        .i_cos   (cos_v[REG_ANGLE_Z]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (z_out)
    );

    // output packing
    assign m_axis_tdata = {z_out.k, z_out.b, z_out.a};
    assign m_axis_tuser = z_out.sat;

endmodule

// ----- design/eul_trig_gen.sv -----
`timescale 1ns / 1ps
// Sine/cosine generator: takes angle register writes and produces rounded
// sin/cos per axis with a shared iterative CORDIC unit. Uses eul_pkg.
module eul_trig_gen #(
    parameter int ANGLE_BITS     = eul_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = eul_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  eul_pkg::t_reg_idx                    i_cfg_index,
    input  logic [eul_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                 o_busy,
    output logic signed [TRIG_FRAC_BITS+1:0]     o_sin [eul_pkg::NUM_AXES],
    output logic signed [TRIG_FRAC_BITS+1:0]     o_cos [eul_pkg::NUM_AXES]
);
    import eul_pkg::*;

    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
    localparam int QTR_W   = ANGLE_BITS - 2;
    localparam int Z_SHIFT = CORDIC_FRAC - ANGLE_BITS;
    localparam int Q_SHIFT = CORDIC_FRAC - TRIG_FRAC_BITS;
    localparam int ITER_W  = $clog2(CORDIC_ITERS);

    localparam t_atan_tab                   ATAN_TAB = atan_table();
    localparam logic signed [CORDIC_W-1:0]  GAIN     = cordic_gain();
    localparam logic signed [CORDIC_W-1:0]  Q_HALF   = CORDIC_W'(1) << (Q_SHIFT - 1);
    localparam logic [QTR_W-1:0]            HALF_QTR = QTR_W'(1) << (QTR_W - 1);
    localparam logic [ITER_W-1:0]           LAST_IT  = ITER_W'(CORDIC_ITERS - 1);
    localparam logic signed [TRIG_W-1:0]    TRIG_ONE = TRIG_W'(1) << TRIG_FRAC_BITS;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    t_trig_state                r_state, n_state;
    logic [ITER_W-1:0]          r_iter;
    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;
    t_reg_idx                   r_axis;
    logic [1:0]                 r_quad;
    logic                       r_swap;
    logic signed [TRIG_W-1:0]   r_sin [NUM_AXES];
    logic signed [TRIG_W-1:0]   r_cos [NUM_AXES];

    logic                       cfg_acc;
    logic                       start;
    logic [ANGLE_BITS-1:0]      angle;
    logic [QTR_W-1:0]           ang_r;
    logic [QTR_W-1:0]           ang_t;
    logic                       ang_swap;
    logic signed [CORDIC_W-1:0] z_init;
    logic signed [CORDIC_W-1:0] x_sh, y_sh;
    logic signed [CORDIC_W-1:0] n_x, n_y, n_z;
    logic signed [CORDIC_W-1:0] qs_full, qc_full;
    logic signed [TRIG_W-1:0]   q_s, q_c, p_s, p_c;
    logic signed [TRIG_W-1:0]   n_sin, n_cos;

    // config transaction and angle reduction to the first octant
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign start    = cfg_acc && (i_cfg_index <= REG_ANGLE_Z);
    assign angle    = ANGLE_BITS'(i_cfg_data);
    assign ang_r    = angle[QTR_W-1:0];
    assign ang_swap = ang_r > HALF_QTR;
    assign ang_t    = ang_swap ? (QTR_W'(0) - ang_r) : ang_r;
    assign z_init   = CORDIC_W'(ang_t) << Z_SHIFT;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TRIG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state     = r_state;
        o_cfg_ready = 1'b0;
        o_busy      = 1'b1;
        case (r_state)
            TRIG_IDLE: begin
                o_cfg_ready = 1'b1;
                o_busy      = 1'b0;
                if (start) begin
                    n_state = TRIG_RUN;
                end
            end
            TRIG_RUN: begin
                if (r_iter == LAST_IT) begin
                    n_state = TRIG_DONE;
                end
            end
            TRIG_DONE: begin
                n_state = TRIG_IDLE;
            end
            default: begin
                n_state = TRIG_IDLE;
            end
        endcase
    end

    // one CORDIC micro-rotation towards zero residual angle
    always_comb begin
        x_sh = r_x >>> r_iter;
        y_sh = r_y >>> r_iter;
        if (!r_z[CORDIC_W-1]) begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - ATAN_TAB[r_iter];
        end else begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + ATAN_TAB[r_iter];
        end
    end

    // CORDIC datapath registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_x    <= GAIN;
            r_y    <= '0;
            r_z    <= z_init;
            r_iter <= '0;
            r_axis <= i_cfg_index;
            r_quad <= angle[ANGLE_BITS-1 -: 2];
            r_swap <= ang_swap;
        end else if (r_state == TRIG_RUN) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_iter <= r_iter + 1'b1;
        end
    end

    // round to TRIG_FRAC_BITS, undo octant fold, then place in quadrant
    always_comb begin
        qs_full = (r_y + Q_HALF) >>> Q_SHIFT;
        qc_full = (r_x + Q_HALF) >>> Q_SHIFT;
        q_s     = qs_full[TRIG_W-1:0];
        q_c     = qc_full[TRIG_W-1:0];
        p_s     = r_swap ? q_c : q_s;
        p_c     = r_swap ? q_s : q_c;
        case (r_quad)
            QUAD_0: begin
                n_sin = p_s;
                n_cos = p_c;
            end
            QUAD_1: begin
                n_sin = p_c;
                n_cos = -p_s;
            end
            QUAD_2: begin
                n_sin = -p_s;
                n_cos = -p_c;
            end
            QUAD_3: begin
                n_sin = -p_c;
                n_cos = p_s;
            end
            default: begin
                n_sin = p_s;
                n_cos = p_c;
            end
        endcase
    end

    // per-axis sin/cos, reset to angle zero
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_AXES; k++) begin
            if (!i_rst_n) begin
                r_sin[k] <= '0;
                r_cos[k] <= TRIG_ONE;
            end else if (r_state == TRIG_DONE && r_axis == t_reg_idx'(k)) begin
                r_sin[k] <= n_sin;
                r_cos[k] <= n_cos;
            end
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ----- design/eul_axis_rot.sv -----
`timescale 1ns / 1ps
// One axis rotation: a' = c*a - s*b, b' = s*a + c*b, rounded and clamped
// to 32 bits. Two register stages (products, then sum/round). Uses eul_pkg.
module eul_axis_rot #(
    parameter int TRIG_FRAC_BITS = eul_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  eul_pkg::t_rot_data               i_data,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_sin,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_cos,
    output logic                             o_valid,
    input  logic                             i_ready,
    output eul_pkg::t_rot_data               o_data
);
    import eul_pkg::*;

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int PROD_W = COORD_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W - TRIG_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

    // product stage
    logic                     r1_vld;
    logic signed [PROD_W-1:0] r1_ca, r1_sb, r1_sa, r1_cb;
    logic signed [COORD_W-1:0] r1_k;
    logic                     r1_sat;
    // round/clamp stage
    logic                     r2_vld;
    t_rot_data                r2_data;

    logic                     s2_ready;
    logic signed [SUM_W-1:0]  sum_a, sum_b, rnd_a, rnd_b;
    logic signed [RND_W-1:0]  v_a, v_b;
    logic signed [COORD_W-1:0] c_a, c_b;
    logic                     ov_a, ov_b;

    assign s2_ready = !r2_vld || i_ready;
    assign o_ready  = !r1_vld || s2_ready;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r1_vld <= i_valid;
            end
            if (s2_ready) begin
                r2_vld <= r1_vld;
            end
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r1_ca  <= PROD_W'(i_data.a) * PROD_W'(i_cos);
            r1_sb  <= PROD_W'(i_data.b) * PROD_W'(i_sin);
            r1_sa  <= PROD_W'(i_data.a) * PROD_W'(i_sin);
            r1_cb  <= PROD_W'(i_data.b) * PROD_W'(i_cos);
            r1_k   <= i_data.k;
            r1_sat <= i_data.sat;
        end
    end

    // exact sums, round half up, clamp to signed 32 bits
    always_comb begin
        sum_a = SUM_W'(r1_ca) - SUM_W'(r1_sb);
        sum_b = SUM_W'(r1_sa) + SUM_W'(r1_cb);
        rnd_a = sum_a + HALF;
        rnd_b = sum_b + HALF;
        v_a   = rnd_a[SUM_W-1:TRIG_FRAC_BITS];
        v_b   = rnd_b[SUM_W-1:TRIG_FRAC_BITS];
        ov_a  = (v_a[RND_W-1:COORD_W-1] != '0) && (v_a[RND_W-1:COORD_W-1] != '1);
        ov_b  = (v_b[RND_W-1:COORD_W-1] != '0) && (v_b[RND_W-1:COORD_W-1] != '1);
        c_a   = ov_a ? (v_a[RND_W-1] ? SAT_MIN : SAT_MAX) : v_a[COORD_W-1:0];
        c_b   = ov_b ? (v_b[RND_W-1] ? SAT_MIN : SAT_MAX) : v_b[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r1_vld) begin
            r2_data.a   <= c_a;
            r2_data.b   <= c_b;
            r2_data.k   <= r1_k;
            r2_data.sat <= r1_sat || ov_a || ov_b;
        end
    end

    assign o_valid = r2_vld;
    assign o_data  = r2_data;

endmodule
